// File: hdl/point_to_segment_distance_macros.svh
// Assertion macros for the point to segment distance block.
// Used by the modules in this folder; expects clk_i and rst_ni in scope.
`ifndef POINT_TO_SEGMENT_DISTANCE_MACROS_SVH
`define POINT_TO_SEGMENT_DISTANCE_MACROS_SVH

// Plain property, checked outside reset.
`define PSD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Implication from a condition to a property in the same cycle.
`define PSD_ASSERT_IMPL(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

`endif

// File: hdl/psd_pkg.sv
// Shared constants and types of the point to segment distance block.
// Has no dependencies.
`default_nettype none

package psd_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int END_X_RESET = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X,
    REG_START_Y,
    REG_END_X,
    REG_END_Y
  } cfg_reg_e;

endpackage

`default_nettype wire

// File: hdl/point_to_segment_distance.sv
// Throughput: one item per cycle while out_ready_i does not hold the output; three stages of differences,
// products and sums come first, then one square root step and one quotient bit per stage.
// Reset clears all valid bits and loads the segment registers with their reset values.
// Top level; depends on psd_pkg and point_to_segment_distance_macros.svh.
`default_nettype none

`include "point_to_segment_distance_macros.svh"

module point_to_segment_distance import psd_pkg::*; #(
  parameter int unsigned CoordWidth = COORD_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [CoordWidth-1:0]        cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [CoordWidth-1:0] point_x_i,
  input  wire logic signed [CoordWidth-1:0] point_y_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [CoordWidth:0]               distance_o
);

  localparam int unsigned DW = CoordWidth + 1;
  localparam int unsigned SW = 2 * DW;
  localparam int unsigned SUMW = SW + 1;
  localparam int unsigned RW = CoordWidth + 1;
  localparam int unsigned NS = RW;
  localparam int unsigned ND = RW;
  localparam int unsigned NP = NS + ND + 2;
  localparam int unsigned NT = NP + 3;

  typedef struct packed {
    logic signed [DW-1:0] spx;
    logic signed [DW-1:0] spy;
    logic signed [DW-1:0] pex;
    logic signed [DW-1:0] pey;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
  } diff_t;

  typedef struct packed {
    logic signed [SW-1:0] spx2;
    logic signed [SW-1:0] spy2;
    logic signed [SW-1:0] pex2;
    logic signed [SW-1:0] pey2;
    logic signed [SW-1:0] dx2;
    logic signed [SW-1:0] dy2;
    logic signed [SW-1:0] dotx;
    logic signed [SW-1:0] doty;
    logic signed [SW-1:0] crsa;
    logic signed [SW-1:0] crsb;
  } prod_t;

  typedef struct packed {
    logic signed [SUMW-1:0] sp2;
    logic signed [SUMW-1:0] pe2;
    logic signed [SUMW-1:0] len2;
    logic signed [SUMW-1:0] dot;
    logic signed [SUMW-1:0] crs;
  } sum_t;

  typedef struct packed {
    logic          hyp;
    logic          sat;
    logic [SW-1:0] hn;
    logic [SW-1:0] hroot;
    logic [SW-1:0] ln;
    logic [SW-1:0] lroot;
    logic [SW-1:0] xmag;
    logic [RW-1:0] q;
  } pipe_t;

  function automatic pipe_t sqrt_step(pipe_t p, int unsigned k);
    logic [SW-1:0] b;
    logic [SW-1:0] t;
    b = SW'(1) << (2 * (NS - 1 - k));
    t = p.hroot + b;
    if (p.hn >= t) begin
      p.hn = p.hn - t;
      p.hroot = (p.hroot >> 1) + b;
    end else begin
      p.hroot = p.hroot >> 1;
    end
    t = p.lroot + b;
    if (p.ln >= t) begin
      p.ln = p.ln - t;
      p.lroot = (p.lroot >> 1) + b;
    end else begin
      p.lroot = p.lroot >> 1;
    end
    return p;
  endfunction

  function automatic pipe_t div_step(pipe_t p, int unsigned k);
    logic [SW-1:0] d;
    d = p.lroot << (ND - 1 - k);
    if (p.xmag >= d) begin
      p.xmag = p.xmag - d;
      p.q[ND-1-k] = 1'b1;
    end
    return p;
  endfunction

  logic signed [CoordWidth-1:0] start_x_q, start_y_q, end_x_q, end_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      end_x_q   <= CoordWidth'(END_X_RESET);
      end_y_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_START_X: start_x_q <= cfg_data_i;
        REG_START_Y: start_y_q <= cfg_data_i;
        REG_END_X:   end_x_q   <= cfg_data_i;
        REG_END_Y:   end_y_q   <= cfg_data_i;
      endcase
    end
  end

  logic [NT-1:0] v_q;
  logic [NT-1:0] vin;
  logic [NT:0]   en;

  assign vin = {v_q[NT-2:0], in_valid_i};

  always_comb begin
    en[NT] = out_ready_i;
    for (int k = NT - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (v_q & ~en[NT-1:0]) | (vin & en[NT-1:0]);
    end
  end

  diff_t a_d, a_q;
  prod_t b_d, b_q;
  sum_t  c_d, c_q;
  pipe_t pipe_d [NP];
  pipe_t pipe_q [NP];

  always_comb begin
    a_d.spx = DW'(point_x_i) - DW'(start_x_q);
    a_d.spy = DW'(point_y_i) - DW'(start_y_q);
    a_d.pex = DW'(point_x_i) - DW'(end_x_q);
    a_d.pey = DW'(point_y_i) - DW'(end_y_q);
    a_d.dx  = DW'(end_x_q) - DW'(start_x_q);
    a_d.dy  = DW'(end_y_q) - DW'(start_y_q);
  end

  always_comb begin
    b_d.spx2 = SW'(a_q.spx) * SW'(a_q.spx);
    b_d.spy2 = SW'(a_q.spy) * SW'(a_q.spy);
    b_d.pex2 = SW'(a_q.pex) * SW'(a_q.pex);
    b_d.pey2 = SW'(a_q.pey) * SW'(a_q.pey);
    b_d.dx2  = SW'(a_q.dx) * SW'(a_q.dx);
    b_d.dy2  = SW'(a_q.dy) * SW'(a_q.dy);
    b_d.dotx = SW'(a_q.spx) * SW'(a_q.dx);
    b_d.doty = SW'(a_q.spy) * SW'(a_q.dy);
    b_d.crsa = SW'(a_q.spx) * SW'(a_q.dy);
    b_d.crsb = SW'(a_q.spy) * SW'(a_q.dx);
  end

  always_comb begin
    c_d.sp2  = SUMW'(b_q.spx2) + SUMW'(b_q.spy2);
    c_d.pe2  = SUMW'(b_q.pex2) + SUMW'(b_q.pey2);
    c_d.len2 = SUMW'(b_q.dx2) + SUMW'(b_q.dy2);
    c_d.dot  = SUMW'(b_q.dotx) + SUMW'(b_q.doty);
    c_d.crs  = SUMW'(b_q.crsa) - SUMW'(b_q.crsb);
  end

  always_comb begin
    logic dot_pos;
    logic past_end;
    logic signed [SUMW-1:0] xabs;
    dot_pos  = c_q.dot > 0;
    past_end = c_q.dot >= c_q.len2;
    xabs     = c_q.crs < 0 ? -c_q.crs : c_q.crs;
    pipe_d[0]       = '0;
    pipe_d[0].hyp   = !dot_pos || past_end;
    pipe_d[0].hn    = (dot_pos && past_end) ? c_q.pe2[SW-1:0] : c_q.sp2[SW-1:0];
    pipe_d[0].ln    = c_q.len2[SW-1:0];
    pipe_d[0].xmag  = xabs[SW-1:0];
  end

  for (genvar j = 1; j < NP; j++) begin : g_stage
    if (j <= NS) begin : g_sqrt
      assign pipe_d[j] = sqrt_step(pipe_q[j-1], j - 1);
    end else if (j == NS + 1) begin : g_sat
      always_comb begin
        pipe_d[j]     = pipe_q[j-1];
        pipe_d[j].sat = pipe_q[j-1].xmag >= (pipe_q[j-1].lroot << RW);
      end
    end else begin : g_div
      assign pipe_d[j] = div_step(pipe_q[j-1], j - NS - 2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && vin[0]) begin
      a_q <= a_d;
    end
    if (en[1] && vin[1]) begin
      b_q <= b_d;
    end
    if (en[2] && vin[2]) begin
      c_q <= c_d;
    end
    for (int j = 0; j < NP; j++) begin
      if (en[3+j] && vin[3+j]) begin
        pipe_q[j] <= pipe_d[j];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NT-1];
  assign distance_o  = pipe_q[NP-1].hyp ? pipe_q[NP-1].hroot[RW-1:0] :
                       pipe_q[NP-1].sat ? {RW{1'b1}} : pipe_q[NP-1].q;

  `PSD_ASSERT(a_stall_only_when_full, !in_ready_o |-> out_valid_o && !out_ready_i, "input stalled without a held result")
  `PSD_ASSERT_IMPL(a_hyp_root_rem, v_q[3+NS], pipe_q[NS].hn <= (pipe_q[NS].hroot << 1), "distance root remainder too large")
  `PSD_ASSERT_IMPL(a_len_root_rem, v_q[3+NS], pipe_q[NS].ln <= (pipe_q[NS].lroot << 1), "length root remainder too large")
  `PSD_ASSERT_IMPL(a_quot_rem, out_valid_o && !pipe_q[NP-1].hyp && !pipe_q[NP-1].sat, pipe_q[NP-1].xmag < pipe_q[NP-1].lroot, "quotient remainder not below length")

endmodule

`default_nettype wire

// File: tb/point_to_segment_distance_tb.sv
// Self-checking testbench for point_to_segment_distance: directed table, then random phases.
// Each accepted point is checked against its typed expected distance or an integer predictor; depends on psd_pkg.
`timescale 1ns / 100ps

module point_to_segment_distance_tb import psd_pkg::*; ();

  localparam int CW = 24;
  localparam int LATENCY = 2 * CW + 7;
  localparam logic [CW:0] DIST_SAT = '1;
  localparam int CMIN = -(1 <<< (CW - 1));
  localparam int CMAX = (1 <<< (CW - 1)) - 1;
  localparam int NO_TYPED = -1;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct {
    coord_t sx, sy, ex, ey;
  } segment_t;
  typedef struct {
    int seg;
    coord_t px, py;
    int exp_dist;
  } vector_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_START_X;
  logic [CW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  coord_t point_x_i = '0;
  coord_t point_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [CW:0] distance_o;

  segment_t seg_now = '{0, 0, 256, 0};
  logic [CW:0] distance_q[$];
  int typed_dist = NO_TYPED;
  bit idling_on = 1'b1;
  int stall_left = 0;
  bit failed = 1'b0;

  point_to_segment_distance #(.CoordWidth(CW)) DUT (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned hypot_floor(longint a, longint b);
    return int_sqrt(longint'(a * a) + longint'(b * b));
  endfunction

  function automatic logic [CW:0] seg_distance(segment_t s, coord_t px, coord_t py);
    longint dx, dy, spx, spy, len2, dot, crs;
    longint unsigned d;
    dx = longint'(s.ex) - longint'(s.sx);
    dy = longint'(s.ey) - longint'(s.sy);
    spx = longint'(px) - longint'(s.sx);
    spy = longint'(py) - longint'(s.sy);
    len2 = dx * dx + dy * dy;
    dot = spx * dx + spy * dy;
    if (len2 == 0 || dot <= 0) begin
      d = hypot_floor(spx, spy);
    end else if (dot >= len2) begin
      d = hypot_floor(longint'(px) - longint'(s.ex), longint'(py) - longint'(s.ey));
    end else begin
      crs = spx * dy - spy * dx;
      if (crs < 0) crs = -crs;
      d = longint'(crs) / int_sqrt(len2);
    end
    if (d > DIST_SAT) d = DIST_SAT;
    return d[CW:0];
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (typed_dist != NO_TYPED) distance_q.push_back(typed_dist[CW:0]);
      else distance_q.push_back(seg_distance(seg_now, point_x_i, point_y_i));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      stall_left = idling_on ? $urandom_range(0, 13) : 0;
      if (distance_q.size() == 0) begin
        $error("distance: unexpected item, actual %0d", distance_o);
        failed = 1'b1;
      end else begin
        if (distance_o !== distance_q[0]) begin
          $error("distance: expected %0d, actual %0d", distance_q[0], distance_o);
          failed = 1'b1;
        end
        void'(distance_q.pop_front());
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic write_reg(cfg_reg_e idx, coord_t val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_segment(segment_t s);
    wait (distance_q.size() == 0);
    repeat (LATENCY + 4) @(negedge clk_i);
    write_reg(REG_START_X, s.sx);
    write_reg(REG_START_Y, s.sy);
    write_reg(REG_END_X, s.ex);
    write_reg(REG_END_Y, s.ey);
    seg_now = s;
  endtask

  // Caller is at a falling edge; returns at the falling edge after acceptance.
  task automatic send_point(coord_t px, coord_t py, int exp_dist);
    int gap;
    gap = idling_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i <= px;
    point_y_i <= py;
    typed_dist = exp_dist;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  function automatic coord_t near(coord_t c, int span);
    return coord_t'(int'(c) + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  segment_t dir_segs[3] = '{
    '{0, 0, 256, 0},
    '{1000, -1000, 1000, -1000},
    '{CMIN, CMIN, CMAX, CMAX}
  };

  vector_t dir_rows[] = '{
    '{0, 0, 0, 0}, '{0, 256, 0, 0}, '{0, 128, 256, 256}, '{0, -256, 0, 256},
    '{0, 512, 0, 256}, '{0, 0, -256, 256}, '{0, 256, 256, 256}, '{0, -1, -1, 1},
    '{0, 128, -1, 1}, '{0, CMAX, CMAX, NO_TYPED}, '{0, CMIN, CMIN, NO_TYPED},
    '{0, CMIN, CMAX, NO_TYPED}, '{0, CMAX, CMIN, NO_TYPED},
    '{1, 1000, -1000, 0}, '{1, 1300, -600, 500}, '{1, CMIN, CMAX, NO_TYPED},
    '{1, CMAX, CMIN, NO_TYPED},
    '{2, CMIN, CMIN, 0}, '{2, CMAX, CMAX, 0}, '{2, CMIN, CMAX, NO_TYPED},
    '{2, CMAX, CMIN, NO_TYPED}, '{2, 0, 0, NO_TYPED}, '{2, 12345, -54321, NO_TYPED},
    '{2, -1, 0, NO_TYPED}
  };

  initial begin
    segment_t s;
    coord_t px, py;
    int cur_seg, kind, t;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    cur_seg = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].seg != cur_seg) begin
        cur_seg = dir_rows[i].seg;
        in_valid_i <= 1'b0;
        load_segment(dir_segs[cur_seg]);
      end
      send_point(dir_rows[i].px, dir_rows[i].py, dir_rows[i].exp_dist);
    end

    for (int ph = 0; ph < 8; ph++) begin
      idling_on = (ph % 3 != 2);
      kind = ph % 5;
      s.sx = rand_coord();
      s.sy = rand_coord();
      case (kind)
        0: begin
          s.ex = rand_coord();
          s.ey = rand_coord();
        end
        1: begin
          s.ex = near(s.sx, 2000);
          s.ey = near(s.sy, 2000);
        end
        2: begin
          s.ex = s.sx;
          s.ey = s.sy;
        end
        3: begin
          s = '{CMAX, CMIN, CMIN, CMAX};
        end
        default: begin
          s.ex = near(s.sx, 300000);
          s.ey = s.sy;
        end
      endcase
      in_valid_i <= 1'b0;
      load_segment(s);
      typed_dist = NO_TYPED;
      for (int n = 0; n < 190; n++) begin
        t = $urandom_range(0, 9);
        if (t < 4) begin
          px = rand_coord();
          py = rand_coord();
        end else if (t < 8) begin
          t = $urandom_range(0, 1024);
          px = coord_t'(longint'(s.sx) + (longint'(s.ex) - longint'(s.sx)) * t / 1024);
          py = coord_t'(longint'(s.sy) + (longint'(s.ey) - longint'(s.sy)) * t / 1024);
          px = near(px, 5000);
          py = near(py, 5000);
        end else begin
          px = near($urandom_range(0, 1) ? s.sx : s.ex, 40);
          py = near($urandom_range(0, 1) ? s.sy : s.ey, 40);
        end
        send_point(px, py, NO_TYPED);
      end
    end
    in_valid_i <= 1'b0;

    wait (distance_q.size() == 0);
    repeat (LATENCY + 10) @(negedge clk_i);
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: point_to_segment_distance.f
+incdir+hdl
hdl/psd_pkg.sv
hdl/point_to_segment_distance.sv
tb/point_to_segment_distance_tb.sv
